// ===== rtl/nct_pkg.sv =====
// shared types and constants of the nearest centroid tracker
package nct_pkg;

   localparam int COORD_W    = 20;
   localparam int THR_W      = 19;
   localparam int WGT_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;

   // distance arithmetic
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int D2_W    = SQ_W;
   localparam int THR2_W  = 2 * THR_W;

   // blend arithmetic
   localparam int WS_W        = WGT_W + 1;
   localparam int PROD_W      = WS_W + DIFF_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int BLEND_SHIFT = 8;

   localparam logic [THR_W-1:0] THR_RESET = 19'd102;
   localparam logic [WGT_W-1:0] WGT_RESET = 9'd205;
   localparam logic [WGT_W-1:0] WGT_FULL  = 9'd256;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic      cmd;
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
   } req_type;

   typedef enum logic [2:0] {
      ACT_MERGED   = 3'd0,
      ACT_APPENDED = 3'd1,
      ACT_DROPPED  = 3'd2,
      ACT_CLEARED  = 3'd3,
      ACT_SKIPPED  = 3'd4
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [5:0]  entry_index;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } entry_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WEIGHT    = 2'd1,
      CSR_ENABLED   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_APPEND,
      S_BLEND_RD,
      S_BLEND_DIFF,
      S_BLEND_MUL,
      S_BLEND_WR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       scan_init;
      logic       scan_rd;
      logic       best_rd;
      logic       blend_diff;
      logic       blend_mul;
      logic       merge_wr;
      logic       append_wr;
      logic       count_clr;
      logic       finish;
      action_type action;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic pipe_busy;
      logic match;
      logic full;
      logic empty;
   } status_type;

endpackage

// ===== rtl/nct_ctrl.sv =====
// sequencing state machine of the nearest centroid tracker
module nct_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_cmd,
   input  logic                 enabled,
   input  nct_pkg::status_type  status_i,
   output logic                 busy,
   output logic                 rsp_valid,
   output nct_pkg::cmd_type     cmd_o
);

   nct_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nct_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd_o.finish;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      cmd_o.action = nct_pkg::ACT_MERGED;
      unique case (state_ff)
         nct_pkg::S_IDLE: begin
            if (start) begin
               cmd_o.accept = 1'b1;
               priority if (req_cmd) begin
                  cmd_o.count_clr = 1'b1;
                  cmd_o.finish    = 1'b1;
                  cmd_o.action    = nct_pkg::ACT_CLEARED;
               end else if (!enabled) begin
                  cmd_o.finish = 1'b1;
                  cmd_o.action = nct_pkg::ACT_SKIPPED;
               end else if (status_i.empty) begin
                  state_in = nct_pkg::S_APPEND;
               end else begin
                  cmd_o.scan_init = 1'b1;
                  state_in        = nct_pkg::S_SCAN;
               end
            end
         end
         nct_pkg::S_SCAN: begin
            cmd_o.scan_rd = 1'b1;
            if (status_i.scan_last) begin
               state_in = nct_pkg::S_DRAIN;
            end
         end
         nct_pkg::S_DRAIN: begin
            if (!status_i.pipe_busy) begin
               state_in = nct_pkg::S_DECIDE;
            end
         end
         nct_pkg::S_DECIDE: begin
            priority if (status_i.match) begin
               state_in = nct_pkg::S_BLEND_RD;
            end else if (status_i.full) begin
               cmd_o.finish = 1'b1;
               cmd_o.action = nct_pkg::ACT_DROPPED;
               state_in     = nct_pkg::S_IDLE;
            end else begin
               cmd_o.append_wr = 1'b1;
               cmd_o.finish    = 1'b1;
               cmd_o.action    = nct_pkg::ACT_APPENDED;
               state_in        = nct_pkg::S_IDLE;
            end
         end
         nct_pkg::S_APPEND: begin
            cmd_o.append_wr = 1'b1;
            cmd_o.finish    = 1'b1;
            cmd_o.action    = nct_pkg::ACT_APPENDED;
            state_in        = nct_pkg::S_IDLE;
         end
         nct_pkg::S_BLEND_RD: begin
            cmd_o.best_rd = 1'b1;
            state_in      = nct_pkg::S_BLEND_DIFF;
         end
         nct_pkg::S_BLEND_DIFF: begin
            cmd_o.blend_diff = 1'b1;
            state_in         = nct_pkg::S_BLEND_MUL;
         end
         nct_pkg::S_BLEND_MUL: begin
            cmd_o.blend_mul = 1'b1;
            state_in        = nct_pkg::S_BLEND_WR;
         end
         nct_pkg::S_BLEND_WR: begin
            cmd_o.merge_wr = 1'b1;
            cmd_o.finish   = 1'b1;
            cmd_o.action   = nct_pkg::ACT_MERGED;
            state_in       = nct_pkg::S_IDLE;
         end
         default: begin
            state_in = nct_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != nct_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a result never leaves while distance reads are still in flight
   a_finish_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd_o.finish |-> !status_i.pipe_busy)
      else $error("result issued with scan pipeline busy");

   // a scan only runs over a table that holds entries
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nct_pkg::S_SCAN) |-> !status_i.empty)
      else $error("scan over empty table");

   // after an accepted request either its result shows or work goes on
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid_ff || (state_ff != nct_pkg::S_IDLE)))
      else $error("accepted request lost");

endmodule

// ===== rtl/nct_dpath.sv =====
// table memory, distance pipeline, blend unit and result register
module nct_dpath #(
   parameter int MAX_OBJECTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nct_pkg::cmd_type              cmd_i,
   output nct_pkg::status_type           status_o,
   input  nct_pkg::req_type              req_data,
   input  logic [nct_pkg::THR_W-1:0]     threshold,
   input  logic [nct_pkg::WGT_W-1:0]     weight,
   output nct_pkg::rsp_type              rsp_data
);

   localparam int IDX_W     = $clog2(MAX_OBJECTS);
   localparam int CNT_W     = $clog2(MAX_OBJECTS + 1);
   localparam int IDX_EXT_W = IDX_W + 6;
   localparam int CNT_EXT_W = CNT_W + 7;
   localparam int NCOORD    = 3;
   localparam int PIPE_N    = 4;

   nct_pkg::entry_type mem [MAX_OBJECTS];

   nct_pkg::entry_type pos_ff;
   nct_pkg::entry_type rd_data_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   scan_addr_ff;
   logic [PIPE_N-1:0]  pipe_vld_ff;
   logic [IDX_W-1:0]   idx_pipe_ff [PIPE_N];
   logic [nct_pkg::DIFF_W-1:0] abs_ff [NCOORD];
   logic [nct_pkg::SQ_W-1:0]   sq_ff  [NCOORD];
   logic [nct_pkg::D2_W-1:0]   d2_ff;
   logic [nct_pkg::D2_W-1:0]   best_d2_ff;
   logic [IDX_W-1:0]           near_slot_ff;
   logic                       have_ff;
   logic [nct_pkg::THR2_W-1:0] thr2_ff;
   logic signed [nct_pkg::DIFF_W-1:0] diff_ff [NCOORD];
   logic signed [nct_pkg::PROD_W-1:0] prod_ff [NCOORD];
   nct_pkg::rsp_type           rsp_ff;

   nct_pkg::coord_type old_c [NCOORD];
   nct_pkg::coord_type new_c [NCOORD];
   nct_pkg::coord_type blend_c [NCOORD];
   logic signed [nct_pkg::DIFF_W-1:0] dist_c [NCOORD];
   logic signed [nct_pkg::SUM_W-1:0]  sum_c [NCOORD];
   logic [nct_pkg::WGT_W-1:0]         w_sat;
   logic signed [nct_pkg::WS_W-1:0]   w_s;

   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   nct_pkg::entry_type   wr_data;
   logic [IDX_EXT_W-1:0] idx_ext;
   logic [CNT_EXT_W-1:0] cnt_ext;

   assign old_c[0] = rd_data_ff.x;
   assign old_c[1] = rd_data_ff.y;
   assign old_c[2] = rd_data_ff.z;
   assign new_c[0] = pos_ff.x;
   assign new_c[1] = pos_ff.y;
   assign new_c[2] = pos_ff.z;

   assign w_sat = (weight > nct_pkg::WGT_FULL) ? nct_pkg::WGT_FULL : weight;
   assign w_s   = signed'({1'b0, w_sat});

   always_comb begin
      for (int k = 0; k < NCOORD; k++) begin
         dist_c[k]  = nct_pkg::DIFF_W'(new_c[k]) - nct_pkg::DIFF_W'(old_c[k]);
         // 256*new + w*(old-new) + half, floored
         sum_c[k]   = (nct_pkg::SUM_W'(new_c[k]) <<< nct_pkg::BLEND_SHIFT)
                    + nct_pkg::SUM_W'(prod_ff[k])
                    + nct_pkg::SUM_W'(1 <<< (nct_pkg::BLEND_SHIFT - 1));
         blend_c[k] = sum_c[k][nct_pkg::BLEND_SHIFT +: nct_pkg::COORD_W];
      end
   end

   // memory port steering
   assign rd_en   = cmd_i.scan_rd | cmd_i.best_rd;
   assign rd_addr = cmd_i.best_rd ? near_slot_ff : scan_addr_ff;
   assign wr_en   = cmd_i.append_wr | cmd_i.merge_wr;
   assign wr_addr = cmd_i.merge_wr ? near_slot_ff : count_ff[IDX_W-1:0];
   always_comb begin
      if (cmd_i.merge_wr) begin
         wr_data.x = blend_c[0];
         wr_data.y = blend_c[1];
         wr_data.z = blend_c[2];
      end else begin
         wr_data = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd_i.count_clr) begin
         count_in = '0;
      end else if (cmd_i.append_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         pipe_vld_ff <= '0;
         have_ff     <= 1'b0;
      end else begin
         count_ff    <= count_in;
         pipe_vld_ff <= {pipe_vld_ff[PIPE_N-2:0], cmd_i.scan_rd};
         if (cmd_i.scan_init) begin
            have_ff <= 1'b0;
         end else if (pipe_vld_ff[PIPE_N-1]) begin
            have_ff <= 1'b1;
         end
      end
   end

   // distance pipeline: read, |diff|, square, sum, keep best
   always_ff @(posedge clock) begin
      if (cmd_i.accept) begin
         pos_ff.x <= req_data.pos_x;
         pos_ff.y <= req_data.pos_y;
         pos_ff.z <= req_data.pos_z;
      end
      if (cmd_i.scan_init) begin
         scan_addr_ff <= '0;
      end else if (cmd_i.scan_rd) begin
         scan_addr_ff <= scan_addr_ff + IDX_W'(1);
      end
      idx_pipe_ff[0] <= scan_addr_ff;
      for (int s = 1; s < PIPE_N; s++) begin
         idx_pipe_ff[s] <= idx_pipe_ff[s-1];
      end
      for (int k = 0; k < NCOORD; k++) begin
         abs_ff[k] <= dist_c[k][nct_pkg::DIFF_W-1] ? (-dist_c[k]) : dist_c[k];
         sq_ff[k]  <= nct_pkg::SQ_W'(abs_ff[k]) * nct_pkg::SQ_W'(abs_ff[k]);
      end
      d2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      if (pipe_vld_ff[PIPE_N-1] && (!have_ff || (d2_ff < best_d2_ff))) begin
         best_d2_ff   <= d2_ff;
         near_slot_ff <= idx_pipe_ff[PIPE_N-1];
      end
      thr2_ff <= nct_pkg::THR2_W'(threshold) * nct_pkg::THR2_W'(threshold);
      // blend unit
      for (int k = 0; k < NCOORD; k++) begin
         if (cmd_i.blend_diff) begin
            diff_ff[k] <= nct_pkg::DIFF_W'(old_c[k]) - nct_pkg::DIFF_W'(new_c[k]);
         end
         if (cmd_i.blend_mul) begin
            prod_ff[k] <= nct_pkg::PROD_W'(w_s) * nct_pkg::PROD_W'(diff_ff[k]);
         end
      end
      if (cmd_i.finish) begin
         rsp_ff.action      <= cmd_i.action;
         rsp_ff.entry_index <= idx_ext[5:0];
         rsp_ff.entry_count <= cnt_ext[6:0];
      end
   end

   always_comb begin
      unique case (cmd_i.action)
         nct_pkg::ACT_MERGED:   idx_ext = IDX_EXT_W'(near_slot_ff);
         nct_pkg::ACT_APPENDED: idx_ext = IDX_EXT_W'(count_ff[IDX_W-1:0]);
         default:               idx_ext = '0;
      endcase
   end
   assign cnt_ext = CNT_EXT_W'(count_in);

   assign status_o.scan_last = (CNT_W'(scan_addr_ff) == (count_ff - CNT_W'(1)));
   assign status_o.pipe_busy = |pipe_vld_ff;
   assign status_o.match     = have_ff && (best_d2_ff < nct_pkg::D2_W'(thr2_ff));
   assign status_o.full      = (count_ff == CNT_W'(MAX_OBJECTS));
   assign status_o.empty     = (count_ff == '0);

   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_OBJECTS))
      else $error("entry count beyond table size");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd_i.append_wr |-> !status_o.full)
      else $error("append into full table");

   a_merge_has_best: assert property (@(posedge clock) disable iff (reset)
      cmd_i.merge_wr |-> (have_ff && !status_o.empty))
      else $error("merge without a nearest entry");

endmodule

// ===== rtl/nearest_centroid_tracker.sv =====
// top level of the nearest centroid tracker: register file, controller and datapath
//
//  channel   ports                               direction  handshake
//  request   start, busy, req_data               in         start && !busy
//  result    rsp_valid, rsp_data                 out        one-cycle strobe
//  csr       csr_valid, csr_ready, csr_index,    in         csr_valid && csr_ready
//            csr_wdata
//
// one request at a time; the distance scan walks the valid table entries one entry
// per cycle over the single table read port, and a merge then reads the nearest
// entry again, blends it with the centroid and writes it back before its result
// clear and skipped requests give their result the cycle after acceptance, an
// append to an empty table passes through the append state first
// synchronous active-high reset empties the table and loads register defaults;
// table contents are not cleared, only entries below the count are ever read
// the result register lets the next request be accepted while a result is shown;
// the receiver cannot stall the result channel
module nearest_centroid_tracker #(
   parameter int MAX_OBJECTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  nct_pkg::req_type                  req_data,
   // result channel
   output logic                              rsp_valid,
   output nct_pkg::rsp_type                  rsp_data,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nct_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [nct_pkg::THR_W-1:0] threshold_ff, threshold_in;
   logic [nct_pkg::WGT_W-1:0] weight_ff, weight_in;
   logic                      enabled_ff, enabled_in;
   logic                      csr_wr;

   nct_pkg::cmd_type    cmd;
   nct_pkg::status_type status;

   // writes are always taken; indexes past the list are ignored
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_comb begin
      threshold_in = threshold_ff;
      weight_in    = weight_ff;
      enabled_in   = enabled_ff;
      if (csr_wr) begin
         unique case (csr_index)
            nct_pkg::CSR_THRESHOLD: threshold_in = csr_wdata[nct_pkg::THR_W-1:0];
            nct_pkg::CSR_WEIGHT:    weight_in    = csr_wdata[nct_pkg::WGT_W-1:0];
            nct_pkg::CSR_ENABLED:   enabled_in   = csr_wdata[0];
            default: begin
               // unused index, nothing to update
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= nct_pkg::THR_RESET;
         weight_ff    <= nct_pkg::WGT_RESET;
         enabled_ff   <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         weight_ff    <= weight_in;
         enabled_ff   <= enabled_in;
      end
   end

   // sequencing of scan, decision, blend and result
   nct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_data.cmd),
      .enabled   (enabled_ff),
      .status_i  (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd_o     (cmd)
   );

   // table memory, distance pipeline and blend arithmetic
   nct_dpath #(
      .MAX_OBJECTS (MAX_OBJECTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd_i     (cmd),
      .status_o  (status),
      .req_data  (req_data),
      .threshold (threshold_ff),
      .weight    (weight_ff),
      .rsp_data  (rsp_data)
   );

endmodule
